// ----- hdl/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the websocket frame deframer
// ----------------------------------------------------------------------------
package wsfd_pkg;

    // parse phase within one segment
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT     = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SKIP    = 3'd5
    } phase_t;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_PTRUNC = 2'd1;
    localparam logic [1:0] ST_HTRUNC = 2'd2;
    localparam logic [1:0] ST_LEN64  = 2'd3;

    // frame kinds
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_PING  = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    // opcodes of interest
    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_PING = 4'h9;

    // 7-bit length codes that select an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       segment_end;
    } in_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       data_present;
        logic [3:0] frame_opcode;
        logic [1:0] frame_kind;
        logic       frame_done;
        logic [1:0] status;
    } out_t;

    function automatic logic [1:0] kind_of(input logic [3:0] op);
        logic [1:0] k;
        if (op == OP_TEXT) begin
            k = KIND_TEXT;
        end else if (op == OP_PING) begin
            k = KIND_PING;
        end else begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

endpackage

// ----- hdl/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses one websocket frame header per segment and unmasks its payload
// ----------------------------------------------------------------------------
// Takes one received byte per beat and accepts a new beat every cycle. Each
// segment (ended by segment_end) carries one frame: opcode, 7-bit or 16-bit
// length and an optional 4-byte mask key, then payload bytes which come out
// xored with the mask key, one result beat per payload byte. Empty frames,
// truncated headers and 64-bit lengths give a single result beat with
// data_present low and frame_done high; a truncated payload ends on a beat
// with frame_done high and status ST_PTRUNC. Bytes after the frame up to the
// segment end are dropped. Each input beat passes an input register, then
// the parser and unmasking xor, then the result register. Throughput is one
// byte per cycle, set by the parser update; back-pressure on the result side
// stalls the input side only once both registers are full.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  wsfd_pkg::in_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output wsfd_pkg::out_t m_data
);
    import wsfd_pkg::*;

    // input register
    logic        in_valid_reg;
    in_t         in_data_reg;
    logic        advance;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_on_reg, mask_on_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] seen_reg, seen_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  hidx_reg, hidx_next;

    // result register
    logic        out_valid_reg;
    out_t        out_data_reg;

    // combinational result of the current beat
    logic        emit;
    logic [7:0]  res_byte;
    logic        res_present;
    logic        res_done;
    logic [1:0]  res_status;
    logic [3:0]  cur_opcode;

    logic [7:0]  b;
    logic        seg;
    logic [6:0]  len7;
    logic [15:0] plen_ext;
    logic [15:0] seen_inc;
    logic [7:0]  key_byte;

    assign b        = in_data_reg.rx_byte;
    assign seg      = in_data_reg.segment_end;
    assign len7     = b[6:0];
    assign plen_ext = {plen_reg[7:0], b};
    assign seen_inc = seen_reg + 16'd1;

    // mask key byte for this payload position, first key byte in the top bits
    always_comb begin
        case (seen_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // pipeline control: a beat moves on when the result slot is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HDR0: begin
                phase_next = seg ? PH_HDR0 : PH_HDR1;
            end
            PH_HDR1: begin
                if (len7 == LEN_EXT64) begin
                    phase_next = seg ? PH_HDR0 : PH_SKIP;
                end else if (len7 == LEN_EXT16) begin
                    phase_next = seg ? PH_HDR0 : PH_EXT;
                end else if (b[7]) begin
                    phase_next = seg ? PH_HDR0 : PH_MASK;
                end else if (seg) begin
                    phase_next = PH_HDR0;
                end else begin
                    phase_next = (len7 == 7'd0) ? PH_SKIP : PH_PAYLOAD;
                end
            end
            PH_EXT: begin
                if (seg) begin
                    phase_next = PH_HDR0;
                end else if (hidx_reg == 2'd0) begin
                    phase_next = PH_EXT;
                end else if (mask_on_reg) begin
                    phase_next = PH_MASK;
                end else begin
                    phase_next = (plen_ext == 16'd0) ? PH_SKIP : PH_PAYLOAD;
                end
            end
            PH_MASK: begin
                if (seg) begin
                    phase_next = PH_HDR0;
                end else if (hidx_reg == 2'd3) begin
                    phase_next = (plen_reg == 16'd0) ? PH_SKIP : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (seg) begin
                    phase_next = PH_HDR0;
                end else if (seen_inc == plen_reg) begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (seg) begin
                    phase_next = PH_HDR0;
                end
            end
            default: phase_next = PH_HDR0;
        endcase
    end

    // header capture, payload unmasking and result selection
    always_comb begin
        opcode_next  = opcode_reg;
        mask_on_next = mask_on_reg;
        plen_next    = plen_reg;
        seen_next    = seen_reg;
        key_next     = key_reg;
        hidx_next    = hidx_reg;
        emit         = 1'b0;
        res_byte     = 8'd0;
        res_present  = 1'b0;
        res_done     = 1'b1;
        res_status   = ST_OK;
        unique case (phase_reg)
            PH_HDR0: begin
                // every frame starts from a clean header state
                opcode_next  = b[3:0];
                mask_on_next = 1'b0;
                plen_next    = 16'd0;
                seen_next    = 16'd0;
                key_next     = 32'd0;
                hidx_next    = 2'd0;
                if (seg) begin
                    emit       = 1'b1;
                    res_status = ST_HTRUNC;
                end
            end
            PH_HDR1: begin
                mask_on_next = b[7];
                if (len7 == LEN_EXT64) begin
                    emit       = 1'b1;
                    res_status = ST_LEN64;
                end else begin
                    hidx_next = 2'd0;
                    if (len7 == LEN_EXT16) begin
                        plen_next = 16'd0;
                        if (seg) begin
                            emit       = 1'b1;
                            res_status = ST_HTRUNC;
                        end
                    end else begin
                        plen_next = {9'd0, len7};
                        if (b[7]) begin
                            if (seg) begin
                                emit       = 1'b1;
                                res_status = ST_HTRUNC;
                            end
                        end else if (len7 == 7'd0) begin
                            emit = 1'b1;
                        end else if (seg) begin
                            emit       = 1'b1;
                            res_status = ST_PTRUNC;
                        end else begin
                            seen_next = 16'd0;
                        end
                    end
                end
            end
            PH_EXT: begin
                plen_next = plen_ext;
                if (hidx_reg == 2'd0) begin
                    hidx_next = 2'd1;
                    if (seg) begin
                        emit       = 1'b1;
                        res_status = ST_HTRUNC;
                    end
                end else begin
                    hidx_next = 2'd0;
                    if (mask_on_reg) begin
                        if (seg) begin
                            emit       = 1'b1;
                            res_status = ST_HTRUNC;
                        end
                    end else if (plen_ext == 16'd0) begin
                        emit = 1'b1;
                    end else if (seg) begin
                        emit       = 1'b1;
                        res_status = ST_PTRUNC;
                    end else begin
                        seen_next = 16'd0;
                    end
                end
            end
            PH_MASK: begin
                key_next = {key_reg[23:0], b};
                if (hidx_reg == 2'd3) begin
                    hidx_next = 2'd0;
                    if (plen_reg == 16'd0) begin
                        emit = 1'b1;
                    end else if (seg) begin
                        emit       = 1'b1;
                        res_status = ST_PTRUNC;
                    end else begin
                        seen_next = 16'd0;
                    end
                end else begin
                    hidx_next = hidx_reg + 2'd1;
                    if (seg) begin
                        emit       = 1'b1;
                        res_status = ST_HTRUNC;
                    end
                end
            end
            PH_PAYLOAD: begin
                seen_next   = seen_inc;
                emit        = 1'b1;
                res_byte    = b ^ key_byte;
                res_present = 1'b1;
                if (seen_inc == plen_reg) begin
                    res_done = 1'b1;
                end else if (seg) begin
                    res_status = ST_PTRUNC;
                end else begin
                    res_done = 1'b0;
                end
            end
            PH_SKIP: begin
                // trailing bytes of the segment are dropped
            end
            default: begin
            end
        endcase
    end

    // the opcode of a result raised on the first header byte is that byte's
    assign cur_opcode = (phase_reg == PH_HDR0) ? b[3:0] : opcode_reg;

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            opcode_reg  <= 4'd0;
            mask_on_reg <= 1'b0;
            plen_reg    <= 16'd0;
            seen_reg    <= 16'd0;
            key_reg     <= 32'd0;
            hidx_reg    <= 2'd0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            mask_on_reg <= mask_on_next;
            plen_reg    <= plen_next;
            seen_reg    <= seen_next;
            key_reg     <= key_next;
            hidx_reg    <= hidx_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_data_reg.payload_byte <= res_byte;
            out_data_reg.data_present <= res_present;
            out_data_reg.frame_opcode <= cur_opcode;
            out_data_reg.frame_kind   <= kind_of(cur_opcode);
            out_data_reg.frame_done   <= res_done;
            out_data_reg.status       <= res_status;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
